[design/aetf_pkg.sv]
// ----------------------------------------------------------------------------
// aetf_pkg
// Shared types and constants for the equation text formatter.
// ----------------------------------------------------------------------------
package aetf_pkg;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CALC,
        ST_DIV,
        ST_LOAD,
        ST_CONV,
        ST_SIGN,
        ST_DIGIT,
        ST_OPTXT,
        ST_EQTXT,
        ST_TAIL
    } state_t;

    // Which number the converter works on
    typedef enum logic [1:0] {
        SEL_A,
        SEL_B,
        SEL_R
    } nsel_t;

    // Controller to datapath
    typedef struct packed {
        logic  capture;
        logic  calc;
        logic  div_init;
        logic  div_step;
        logic  load;
        nsel_t sel;
        logic  conv_step;
        logic  emit_sign;
        logic  emit_digit;
        logic  emit_txt;
        logic  emit_last;
        logic [1:0] txt_sel;   // 0 op, 1 eq, 2 tail
        logic [1:0] txt_idx;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_div;
        logic div_done;
        logic neg;
        logic conv_done;
        logic digits_done;
    } dp_stat_t;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // ceil(2^35 / 10): (n * DIV10_RECIP) >> 35 is n / 10 for every 32-bit n
    localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;

    function automatic logic [7:0] op_char(input logic [1:0] op);
        logic [7:0] c;
        unique case (op)
            OP_ADD:  c = 8'h2B;
            OP_SUB:  c = 8'h2D;
            OP_MUL:  c = 8'h2A;
            default: c = 8'h2F;
        endcase
        return c;
    endfunction

endpackage

[design/arithmetic_equation_text_formatter_unit.sv]
// ----------------------------------------------------------------------------
// arithmetic_equation_text_formatter_unit
// Computes A op B and streams "A op B = R \r\n " as ASCII characters.
// ----------------------------------------------------------------------------
//  channel | handshake      | payload
//  --------+----------------+---------------------------------
//  command | start / busy   | cmd, a, b
//  text    | strobe         | char_out, last, div_by_zero
//
// Busy stays high from the accept edge until the last character is issued:
// a calculate step, the divider steps for a divide, then per number a load
// step, a reciprocal multiply and then a remainder step per decimal digit,
// a minus sign if negative and each digit character; then the fixed text
// of ten characters. The next start is taken in the idle cycle.
// Reset clears the sequencer and the strobe; the receiver cannot stall the text.
module arithmetic_equation_text_formatter_unit
    import aetf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic        strobe,
    output logic [7:0]  char_out,
    output logic        last,
    output logic        div_by_zero
);

    dp_cmd_t  ctl;
    dp_stat_t stat;

    aetf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .ctl   (ctl)
    );

    aetf_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .a           (a),
        .b           (b),
        .ctl         (ctl),
        .stat        (stat),
        .strobe      (strobe),
        .char_out    (char_out),
        .last        (last),
        .div_by_zero (div_by_zero)
    );

endmodule

[design/aetf_datapath.sv]
// ----------------------------------------------------------------------------
// aetf_datapath
// Operand registers, ALU, restoring divider and decimal digit generator.
// ----------------------------------------------------------------------------
module aetf_datapath
    import aetf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [1:0]  cmd,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  dp_cmd_t     ctl,
    output dp_stat_t    stat,
    output logic        strobe,
    output logic [7:0]  char_out,
    output logic        last,
    output logic        div_by_zero
);

    logic [1:0]  op_reg;
    logic [31:0] a_reg, b_reg, r_reg;
    logic        dz_reg;
    // divider
    logic [31:0] quo_reg, rem_reg, dvs_reg;
    logic [5:0]  dcnt_reg;
    logic        qneg_reg;
    // conversion: divide by ten by reciprocal multiply, then take the remainder, per digit
    logic [31:0] mag_reg, cq_reg;
    logic        cphase_reg;
    logic        neg_reg;
    logic [3:0]  dig_reg [10];
    logic [3:0]  nd_reg;
    logic [3:0]  rd_reg;
    logic        strobe_reg, last_reg;
    logic [7:0]  char_reg;

    logic [31:0] sel_val, ma, mb;
    logic [32:0] rem_sh, rem_sub;
    logic [63:0] cprod;
    logic [3:0]  cdig;
    logic [7:0]  txt_char;

    always_comb
    begin
        unique case (ctl.sel)
            SEL_A:   sel_val = a_reg;
            SEL_B:   sel_val = b_reg;
            default: sel_val = r_reg;
        endcase
        ma = a_reg[31] ? (32'd0 - a_reg) : a_reg;
        mb = b_reg[31] ? (32'd0 - b_reg) : b_reg;
        rem_sh  = {rem_reg, quo_reg[31]};
        rem_sub = rem_sh - {1'b0, dvs_reg};
        cprod   = {32'd0, mag_reg} * {32'd0, DIV10_RECIP};
        // remainder is below ten, so the low four bits of mag - 10q suffice
        cdig    = mag_reg[3:0] - {cq_reg[0], 3'b000} - {cq_reg[2:0], 1'b0};
        unique case (ctl.txt_sel)
            2'd0:
            begin
                txt_char = (ctl.txt_idx == 2'd1) ? op_char(op_reg) : CH_SPACE;
            end
            2'd1:
            begin
                txt_char = (ctl.txt_idx == 2'd1) ? CH_EQ : CH_SPACE;
            end
            default:
            begin
                unique case (ctl.txt_idx)
                    2'd1:    txt_char = CH_CR;
                    2'd2:    txt_char = CH_LF;
                    default: txt_char = CH_SPACE;
                endcase
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            op_reg <= cmd;
            a_reg  <= a;
            b_reg  <= b;
        end
        if (ctl.calc)
        begin
            unique case (op_reg)
                OP_ADD:  r_reg <= a_reg + b_reg;
                OP_SUB:  r_reg <= a_reg - b_reg;
                OP_MUL:  r_reg <= a_reg * b_reg;
                default: r_reg <= 32'd0;
            endcase
            dz_reg <= (op_reg == OP_DIV) && (b_reg == 32'd0);
        end
        if (ctl.div_init)
        begin
            quo_reg  <= ma;
            rem_reg  <= 32'd0;
            dvs_reg  <= mb;
            dcnt_reg <= 6'd0;
            qneg_reg <= a_reg[31] ^ b_reg[31];
        end
        else if (ctl.div_step)
        begin
            if (!rem_sub[32])
            begin
                rem_reg <= rem_sub[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[31:0];
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg + 6'd1;
            if (dcnt_reg == 6'd31 && dvs_reg != 32'd0)
            begin
                // last step: apply sign to the finished quotient
                if (qneg_reg)
                    r_reg <= 32'd0 - {quo_reg[30:0], ~rem_sub[32]};
                else
                    r_reg <= {quo_reg[30:0], ~rem_sub[32]};
            end
        end
        if (ctl.load)
        begin
            neg_reg    <= sel_val[31];
            mag_reg    <= sel_val[31] ? (32'd0 - sel_val) : sel_val;
            cq_reg     <= 32'd0;
            cphase_reg <= 1'b0;
            nd_reg     <= 4'd0;
        end
        else if (ctl.conv_step)
        begin
            if (cphase_reg)
            begin
                // store the digit, restart on the quotient
                dig_reg[nd_reg] <= cdig;
                nd_reg     <= nd_reg + 4'd1;
                rd_reg     <= nd_reg;
                mag_reg    <= cq_reg;
                cphase_reg <= 1'b0;
            end
            else
            begin
                cq_reg     <= {3'd0, cprod[63:35]};
                cphase_reg <= 1'b1;
            end
        end
        else if (ctl.emit_digit)
        begin
            rd_reg <= rd_reg - 4'd1;
        end
        if (ctl.emit_sign)
            char_reg <= CH_MINUS;
        else if (ctl.emit_digit)
            char_reg <= CH_ZERO + {4'd0, dig_reg[rd_reg]};
        else if (ctl.emit_txt)
            char_reg <= txt_char;
        last_reg <= ctl.emit_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= ctl.emit_sign | ctl.emit_digit | ctl.emit_txt;
    end

    assign stat.is_div      = (op_reg == OP_DIV);
    assign stat.div_done    = (dcnt_reg == 6'd32);
    assign stat.neg         = neg_reg;
    assign stat.conv_done   = cphase_reg && (cq_reg == 32'd0);
    assign stat.digits_done = (rd_reg == 4'd0);
    assign strobe      = strobe_reg;
    assign char_out    = char_reg;
    assign last        = last_reg;
    assign div_by_zero = dz_reg;

endmodule

[design/aetf_ctrl.sv]
// ----------------------------------------------------------------------------
// aetf_ctrl
// Sequencer: calculate, then convert and emit each field of the text.
// ----------------------------------------------------------------------------
module aetf_ctrl
    import aetf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output logic     busy,
    output dp_cmd_t  ctl
);

    state_t     state_reg, state_next;
    nsel_t      fld_reg, fld_next;
    logic [1:0] idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fld_reg   <= SEL_A;
            idx_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            fld_reg   <= fld_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        fld_next   = fld_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_CALC;
            end
            ST_CALC:
            begin
                state_next = stat.is_div ? ST_DIV : ST_LOAD;
                fld_next   = SEL_A;
            end
            ST_DIV:
            begin
                if (stat.div_done)
                    state_next = ST_LOAD;
            end
            ST_LOAD:   state_next = ST_CONV;
            ST_CONV:
            begin
                if (stat.conv_done)
                    state_next = stat.neg ? ST_SIGN : ST_DIGIT;
            end
            ST_SIGN:   state_next = ST_DIGIT;
            ST_DIGIT:
            begin
                if (stat.digits_done)
                begin
                    idx_next = 2'd0;
                    unique case (fld_reg)
                        SEL_A:   state_next = ST_OPTXT;
                        SEL_B:   state_next = ST_EQTXT;
                        default: state_next = ST_TAIL;
                    endcase
                end
            end
            ST_OPTXT, ST_EQTXT:
            begin
                idx_next = idx_reg + 2'd1;
                if (idx_reg == 2'd2)
                begin
                    idx_next   = 2'd0;
                    state_next = ST_LOAD;
                    fld_next   = (state_reg == ST_OPTXT) ? SEL_B : SEL_R;
                end
            end
            ST_TAIL:
            begin
                idx_next = idx_reg + 2'd1;
                if (idx_reg == 2'd3)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        ctl.sel     = fld_reg;
        ctl.txt_idx = idx_reg;
        busy = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:  ctl.capture = start;
            ST_CALC:
            begin
                ctl.calc     = 1'b1;
                ctl.div_init = 1'b1;
            end
            ST_DIV:   ctl.div_step = 1'b1;
            ST_LOAD:  ctl.load = 1'b1;
            ST_CONV:  ctl.conv_step = 1'b1;
            ST_SIGN:  ctl.emit_sign = 1'b1;
            ST_DIGIT: ctl.emit_digit = 1'b1;
            ST_OPTXT: ctl.txt_sel = 2'd0;
            ST_EQTXT: ctl.txt_sel = 2'd1;
            ST_TAIL:
            begin
                ctl.txt_sel   = 2'd2;
                ctl.emit_last = (idx_reg == 2'd3);
            end
            default:  ctl.calc = 1'b0;
        endcase
        ctl.emit_txt = (state_reg == ST_OPTXT) || (state_reg == ST_EQTXT)
                       || (state_reg == ST_TAIL);
    end

endmodule
